### hdl/crpc_pkg.sv
package crpc_pkg;

    localparam int COORD_W    = 10;
    localparam int RAD_W      = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 10;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 8;
    localparam int CTR_W      = 34;   // signed circle center coordinate
    localparam int MAG_W      = 36;   // magnitude of a distance to the center
    localparam int HALF_W     = 18;
    localparam int SQ_W       = 64;   // squared distances, kept modulo 2**64
    localparam int ROOT_W     = 32;
    localparam int DOT_SQ_W   = 16;
    localparam int DOT_D2_W   = 21;

    localparam int IMAGE_WIDTH_DEF  = 1024;
    localparam int IMAGE_HEIGHT_DEF = 1024;

    localparam logic [CFG_ADDR_W-1:0] REG_A_X   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_A_Y   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_B_X   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_B_Y   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_C_X   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_C_Y   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_DOT_R = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_THICK = 3'd7;

    typedef enum logic [1:0] {
        CLS_BG   = 2'd0,
        CLS_DOT  = 2'd1,
        CLS_RING = 2'd2
    } t_class;

    typedef struct packed {
        logic [COORD_W-1:0]      ax;
        logic [COORD_W-1:0]      ay;
        logic [COORD_W-1:0]      bx;
        logic [COORD_W-1:0]      by;
        logic [COORD_W-1:0]      cx;
        logic [COORD_W-1:0]      cy;
        logic [DOT_SQ_W-1:0]     dot_sq;
        logic signed [CTR_W-1:0] ox;
        logic signed [CTR_W-1:0] oy;
        logic [SQ_W-1:0]         rsq;
        logic [SQ_W-1:0]         isq;
        logic                    absent;
    } t_geom;

    function automatic logic [MAG_W-1:0] mag(input logic signed [MAG_W-1:0] d);
        mag = (d < 0) ? MAG_W'(-d) : MAG_W'(d);
    endfunction

    // m*m mod 2**64 from the partial products of m = h*2**18 + l
    function automatic logic [SQ_W-1:0] sum_parts(input logic [MAG_W-1:0] hh,
                                                   input logic [MAG_W-1:0] lh,
                                                   input logic [MAG_W-1:0] ll);
        sum_parts = (SQ_W'(hh) << (2 * HALF_W)) + (SQ_W'(lh) << (HALF_W + 1))
                  + SQ_W'(ll);
    endfunction

endpackage

### hdl/crpc_geom.sv
module crpc_geom (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [crpc_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [crpc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output crpc_pkg::t_geom                  o_geom,
    output logic                             o_busy
);
    import crpc_pkg::*;

    typedef enum logic [3:0] {
        ST_SQ, ST_DA, ST_DB, ST_DC, ST_DIVX, ST_DIVY, ST_RDIF, ST_RPROD,
        ST_RSUM, ST_SQRT, ST_RSQ, ST_ISQ, ST_DONE
    } t_state;

    t_state r_state;

    logic [COORD_W-1:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic [RAD_W-1:0]   r_drad, r_thick;

    logic [DOT_D2_W-1:0]     r_sa, r_sb, r_sc;
    logic signed [25:0]      r_da;
    logic signed [MAG_W-1:0] r_db, r_dc;
    logic [MAG_W-1:0]        r_num;
    logic [25:0]             r_rem;
    logic [24:0]             r_den;
    logic                    r_neg;
    logic [5:0]              r_cnt;
    logic signed [CTR_W-1:0] r_ox, r_oy;
    logic [MAG_W-1:0]        r_mx, r_my;
    logic [MAG_W-1:0]        r_hhx, r_lhx, r_llx, r_hhy, r_lhy, r_lly;
    logic [SQ_W-1:0]         r_v, r_res, r_bit;
    logic [ROOT_W-1:0]       r_r;
    logic [SQ_W-1:0]         r_rsq, r_isq;
    logic [DOT_SQ_W-1:0]     r_dsq;
    logic                    r_absent;

    logic signed [MAG_W-1:0] l_ax, l_ay, l_bx, l_by, l_cx, l_cy, l_sa, l_sb, l_sc;
    logic signed [MAG_W-1:0] w_da, w_db, w_dc;
    logic [25:0]             w_t;
    logic                    w_q;
    logic [MAG_W-1:0]        w_quo;
    logic signed [CTR_W-1:0] w_ctr;
    logic [SQ_W-1:0]         w_rb, w_res;
    logic [ROOT_W-1:0]       w_inner;

    assign l_ax = $signed(MAG_W'(r_ax));
    assign l_ay = $signed(MAG_W'(r_ay));
    assign l_bx = $signed(MAG_W'(r_bx));
    assign l_by = $signed(MAG_W'(r_by));
    assign l_cx = $signed(MAG_W'(r_cx));
    assign l_cy = $signed(MAG_W'(r_cy));
    assign l_sa = $signed(MAG_W'(r_sa));
    assign l_sb = $signed(MAG_W'(r_sb));
    assign l_sc = $signed(MAG_W'(r_sc));

    assign w_da = l_ax * (l_by - l_cy) - l_ay * (l_bx - l_cx) + l_bx * l_cy - l_cx * l_by;
    assign w_db = l_sa * (l_cy - l_by) + l_sb * (l_ay - l_cy) + l_sc * (l_by - l_ay);
    assign w_dc = l_sa * (l_bx - l_cx) + l_sb * (l_cx - l_ax) + l_sc * (l_ax - l_bx);

    // restoring divider, one quotient bit per cycle
    assign w_t   = {r_rem[24:0], r_num[MAG_W-1]};
    assign w_q   = (w_t >= {1'b0, r_den});
    assign w_quo = {r_num[MAG_W-2:0], w_q};
    assign w_ctr = r_neg ? -$signed(CTR_W'(w_quo)) : $signed(CTR_W'(w_quo));

    // integer square root, two radicand bits per cycle
    assign w_rb  = r_res + r_bit;
    assign w_res = (r_v >= w_rb) ? ((r_res >> 1) + r_bit) : (r_res >> 1);

    assign w_inner = (r_r >= ROOT_W'(r_thick)) ? (r_r - ROOT_W'(r_thick))
                                               : (ROOT_W'(r_thick) - r_r);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_SQ;
            r_ax     <= '0;
            r_ay     <= '0;
            r_bx     <= '0;
            r_by     <= '0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_drad   <= RAD_W'(5);
            r_thick  <= RAD_W'(3);
            r_absent <= 1'b1;
            r_cnt    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_state <= ST_SQ;
                case (i_cfg_addr)
                    REG_A_X:   r_ax    <= i_cfg_wdata;
                    REG_A_Y:   r_ay    <= i_cfg_wdata;
                    REG_B_X:   r_bx    <= i_cfg_wdata;
                    REG_B_Y:   r_by    <= i_cfg_wdata;
                    REG_C_X:   r_cx    <= i_cfg_wdata;
                    REG_C_Y:   r_cy    <= i_cfg_wdata;
                    REG_DOT_R: r_drad  <= i_cfg_wdata[RAD_W-1:0];
                    REG_THICK: r_thick <= i_cfg_wdata[RAD_W-1:0];
                    default: ;
                endcase
            end else begin
                case (r_state)
                    ST_SQ: begin
                        r_sa    <= DOT_D2_W'(r_ax) * DOT_D2_W'(r_ax)
                                 + DOT_D2_W'(r_ay) * DOT_D2_W'(r_ay);
                        r_sb    <= DOT_D2_W'(r_bx) * DOT_D2_W'(r_bx)
                                 + DOT_D2_W'(r_by) * DOT_D2_W'(r_by);
                        r_sc    <= DOT_D2_W'(r_cx) * DOT_D2_W'(r_cx)
                                 + DOT_D2_W'(r_cy) * DOT_D2_W'(r_cy);
                        r_dsq   <= DOT_SQ_W'(r_drad) * DOT_SQ_W'(r_drad);
                        r_state <= ST_DA;
                    end
                    ST_DA: begin
                        r_da    <= 26'(w_da);
                        r_state <= ST_DB;
                    end
                    ST_DB: begin
                        r_db    <= w_db;
                        r_state <= ST_DC;
                    end
                    ST_DC: begin
                        r_dc     <= w_dc;
                        r_absent <= (r_da == 0);
                        r_num    <= mag(r_db);
                        r_den    <= 25'(mag(MAG_W'(r_da)) << 1);
                        r_neg    <= (r_db > 0) ^ (r_da < 0);
                        r_rem    <= '0;
                        r_cnt    <= '0;
                        r_state  <= (r_da == 0) ? ST_DONE : ST_DIVX;
                    end
                    ST_DIVX: begin
                        if (r_cnt == 6'(MAG_W - 1)) begin
                            r_ox    <= w_ctr;
                            r_num   <= mag(r_dc);
                            r_neg   <= (r_dc > 0) ^ (r_da < 0);
                            r_rem   <= '0;
                            r_cnt   <= '0;
                            r_state <= ST_DIVY;
                        end else begin
                            r_num <= w_quo;
                            r_rem <= w_q ? (w_t - {1'b0, r_den}) : w_t;
                            r_cnt <= r_cnt + 6'd1;
                        end
                    end
                    ST_DIVY: begin
                        if (r_cnt == 6'(MAG_W - 1)) begin
                            r_oy    <= w_ctr;
                            r_state <= ST_RDIF;
                        end else begin
                            r_num <= w_quo;
                            r_rem <= w_q ? (w_t - {1'b0, r_den}) : w_t;
                            r_cnt <= r_cnt + 6'd1;
                        end
                    end
                    ST_RDIF: begin
                        r_mx    <= mag(l_ax - MAG_W'(r_ox));
                        r_my    <= mag(l_ay - MAG_W'(r_oy));
                        r_state <= ST_RPROD;
                    end
                    ST_RPROD: begin
                        r_hhx   <= MAG_W'(r_mx[MAG_W-1:HALF_W]) * MAG_W'(r_mx[MAG_W-1:HALF_W]);
                        r_lhx   <= MAG_W'(r_mx[HALF_W-1:0]) * MAG_W'(r_mx[MAG_W-1:HALF_W]);
                        r_llx   <= MAG_W'(r_mx[HALF_W-1:0]) * MAG_W'(r_mx[HALF_W-1:0]);
                        r_hhy   <= MAG_W'(r_my[MAG_W-1:HALF_W]) * MAG_W'(r_my[MAG_W-1:HALF_W]);
                        r_lhy   <= MAG_W'(r_my[HALF_W-1:0]) * MAG_W'(r_my[MAG_W-1:HALF_W]);
                        r_lly   <= MAG_W'(r_my[HALF_W-1:0]) * MAG_W'(r_my[HALF_W-1:0]);
                        r_state <= ST_RSUM;
                    end
                    ST_RSUM: begin
                        r_v     <= sum_parts(r_hhx, r_lhx, r_llx)
                                 + sum_parts(r_hhy, r_lhy, r_lly);
                        r_res   <= '0;
                        r_bit   <= SQ_W'(1) << (SQ_W - 2);
                        r_cnt   <= '0;
                        r_state <= ST_SQRT;
                    end
                    ST_SQRT: begin
                        if (r_v >= w_rb) begin
                            r_v <= r_v - w_rb;
                        end
                        r_res <= w_res;
                        r_bit <= r_bit >> 2;
                        r_cnt <= r_cnt + 6'd1;
                        if (r_cnt == 6'(ROOT_W - 1)) begin
                            r_r     <= w_res[ROOT_W-1:0];
                            r_state <= ST_RSQ;
                        end
                    end
                    ST_RSQ: begin
                        r_rsq   <= SQ_W'(r_r) * SQ_W'(r_r);
                        r_state <= ST_ISQ;
                    end
                    ST_ISQ: begin
                        r_isq   <= SQ_W'(w_inner) * SQ_W'(w_inner);
                        r_state <= ST_DONE;
                    end
                    ST_DONE: ;
                    default: r_state <= ST_SQ;
                endcase
            end
        end
    end

    assign o_busy = (r_state != ST_DONE);

    always_comb begin
        o_geom.ax     = r_ax;
        o_geom.ay     = r_ay;
        o_geom.bx     = r_bx;
        o_geom.by     = r_by;
        o_geom.cx     = r_cx;
        o_geom.cy     = r_cy;
        o_geom.dot_sq = r_dsq;
        o_geom.ox     = r_ox;
        o_geom.oy     = r_oy;
        o_geom.rsq    = r_rsq;
        o_geom.isq    = r_isq;
        o_geom.absent = r_absent;
    end

endmodule

### hdl/crpc_pipe.sv
module crpc_pipe #(
    parameter int IMAGE_WIDTH  = crpc_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = crpc_pkg::IMAGE_HEIGHT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  crpc_pkg::t_geom               i_geom,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [crpc_pkg::COORD_W-1:0]  i_px,
    input  logic [crpc_pkg::COORD_W-1:0]  i_py,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_class
);
    import crpc_pkg::*;

    logic w_en;
    logic r_v1, r_v2, r_v3, r_v4;

    logic [MAG_W-1:0]   r1_mx, r1_my;
    logic [COORD_W-1:0] r1_dd [6];
    logic               r1_in;

    logic [MAG_W-1:0]    r2_pp [6];
    logic [2*COORD_W-1:0] r2_ds [6];
    logic                r2_in;

    logic [SQ_W-1:0] r3_d2;
    logic            r3_dot, r3_in;

    logic [1:0] r4_class;

    logic [COORD_W-1:0] w_pt [6];
    logic [COORD_W-1:0] w_pix [6];
    logic [DOT_D2_W-1:0] w_s [3];
    logic               w_ring;

    assign w_en    = !r_v4 || i_ready;
    assign o_ready = w_en;

    assign w_pt  = '{i_geom.ax, i_geom.ay, i_geom.bx, i_geom.by, i_geom.cx, i_geom.cy};
    assign w_pix = '{i_px, i_py, i_px, i_py, i_px, i_py};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_s[k] = DOT_D2_W'(r2_ds[2*k]) + DOT_D2_W'(r2_ds[2*k+1]);
        end
    end

    assign w_ring = !i_geom.absent && (r3_d2 < i_geom.rsq) && !(r3_d2 < i_geom.isq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // distances to the center and to the three points
            r1_mx <= mag($signed(MAG_W'(i_px)) - MAG_W'(i_geom.ox));
            r1_my <= mag($signed(MAG_W'(i_py)) - MAG_W'(i_geom.oy));
            for (int k = 0; k < 6; k++) begin
                r1_dd[k] <= (w_pix[k] >= w_pt[k]) ? (w_pix[k] - w_pt[k])
                                                  : (w_pt[k] - w_pix[k]);
            end
            r1_in <= (32'(i_px) < IMAGE_WIDTH) && (32'(i_py) < IMAGE_HEIGHT);

            // partial products of the squares
            r2_pp[0] <= MAG_W'(r1_mx[MAG_W-1:HALF_W]) * MAG_W'(r1_mx[MAG_W-1:HALF_W]);
            r2_pp[1] <= MAG_W'(r1_mx[HALF_W-1:0]) * MAG_W'(r1_mx[MAG_W-1:HALF_W]);
            r2_pp[2] <= MAG_W'(r1_mx[HALF_W-1:0]) * MAG_W'(r1_mx[HALF_W-1:0]);
            r2_pp[3] <= MAG_W'(r1_my[MAG_W-1:HALF_W]) * MAG_W'(r1_my[MAG_W-1:HALF_W]);
            r2_pp[4] <= MAG_W'(r1_my[HALF_W-1:0]) * MAG_W'(r1_my[MAG_W-1:HALF_W]);
            r2_pp[5] <= MAG_W'(r1_my[HALF_W-1:0]) * MAG_W'(r1_my[HALF_W-1:0]);
            for (int k = 0; k < 6; k++) begin
                r2_ds[k] <= (2*COORD_W)'(r1_dd[k]) * (2*COORD_W)'(r1_dd[k]);
            end
            r2_in <= r1_in;

            // squared distance to the center, wraps modulo 2**64
            r3_d2  <= sum_parts(r2_pp[0], r2_pp[1], r2_pp[2])
                    + sum_parts(r2_pp[3], r2_pp[4], r2_pp[5]);
            r3_dot <= (w_s[0] < DOT_D2_W'(i_geom.dot_sq))
                   || (w_s[1] < DOT_D2_W'(i_geom.dot_sq))
                   || (w_s[2] < DOT_D2_W'(i_geom.dot_sq));
            r3_in  <= r2_in;

            if (!r3_in) begin
                r4_class <= CLS_BG;
            end else if (w_ring) begin
                r4_class <= CLS_RING;
            end else if (r3_dot) begin
                r4_class <= CLS_DOT;
            end else begin
                r4_class <= CLS_BG;
            end
        end
    end

    assign o_valid = r_v4;
    assign o_class = r4_class;

endmodule

### hdl/circumcircle_ring_pixel_classifier_unit.sv
// circumcircle ring pixel classifier
// config port: i_cfg_we writes i_cfg_wdata into register i_cfg_addr
//   (0..5 point a/b/c x,y, 6 dot radius, 7 ring thickness)
// each write restarts the circle setup, during which o_s_tready stays low:
//   the center is found by two serial divisions and the radius by a serial
//   square root, all three skipped when the points are collinear
// slave stream: one pixel item (x, y) per accepted beat
// master stream: one item per pixel: class (0 background, 1 dot, 2 ring)
//   and the collinear flag
// after setup one item is taken every cycle while the output is not stalled;
//   each item passes the four-stage pixel pipeline (distances, partial
//   products, squared sums and dot test, class) into the output register
// reset loads the default registers and runs the setup once
// when i_m_tready is low and the output register is full, the whole pipeline
//   holds and o_s_tready falls; nothing is dropped or repeated
module circumcircle_ring_pixel_classifier_unit #(
    parameter int IMAGE_WIDTH  = crpc_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = crpc_pkg::IMAGE_HEIGHT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [crpc_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [crpc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [crpc_pkg::S_TDATA_W-1:0]   i_s_tdata,   // pixel_x, pixel_y
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [crpc_pkg::M_TDATA_W-1:0]   o_m_tdata    // pixel_class, ring_absent
);
    import crpc_pkg::*;

    t_geom      w_geom;
    logic       w_busy;
    logic       w_pipe_ready;
    logic [1:0] w_class;

    crpc_geom u_geom (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_geom      (w_geom),
        .o_busy      (w_busy)
    );

    crpc_pipe #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_geom  (w_geom),
        .i_valid (i_s_tvalid && !w_busy),
        .o_ready (w_pipe_ready),
        .i_px    (i_s_tdata[COORD_W-1:0]),
        .i_py    (i_s_tdata[2*COORD_W-1:COORD_W]),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_class (w_class)
    );

    assign o_s_tready = w_pipe_ready && !w_busy;
    assign o_m_tdata  = {{(M_TDATA_W - 3){1'b0}}, w_geom.absent, w_class};

endmodule

### hdl/crpc_chk.sv
module crpc_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_cfg_we,
    input logic                             o_s_tready,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [crpc_pkg::M_TDATA_W-1:0]   o_m_tdata
);
    import crpc_pkg::*;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output item dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("output item changed while stalled");

    a_class_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[1:0] == CLS_BG || o_m_tdata[1:0] == CLS_DOT
                        || o_m_tdata[1:0] == CLS_RING))
        else $error("bad pixel class");

    a_no_ring_collinear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[2] |-> o_m_tdata[1:0] != CLS_RING)
        else $error("ring reported for collinear points");

    a_setup_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !o_s_tready)
        else $error("input taken during circle setup");

endmodule

bind circumcircle_ring_pixel_classifier_unit crpc_chk u_crpc_chk (.*);
